>>> hw/rtl/ttbs_pkg.sv
// Shared types and constants for the timestamp table search block.
// Used by every module under timestamp_table_binary_search; no dependencies.
`default_nettype none

package ttbs_pkg;

    localparam int IDX_W     = 10;   // table index as carried on the ports
    localparam int COUNT_W   = 11;   // entry_count register
    localparam int WEEK_W    = 16;
    localparam int SEC_W     = 36;   // seconds into week, 16 fraction bits
    localparam int PKT_W     = 32;
    localparam int KEY_W     = 52;   // absolute time, 16 fraction bits
    localparam int WSEC_W    = 20;
    localparam int PROD_W    = WEEK_W + WSEC_W;
    localparam int FRAC_W    = 16;
    localparam int STATUS_W  = 3;

    localparam logic [WSEC_W-1:0] WEEK_SECONDS = 20'd604800;

    // input word layout, lowest bit first
    localparam int IN_IDX_LSB  = 0;
    localparam int IN_OK_LSB   = IN_IDX_LSB + IDX_W;
    localparam int IN_WEEK_LSB = IN_OK_LSB + 1;
    localparam int IN_SEC_LSB  = IN_WEEK_LSB + WEEK_W;
    localparam int IN_PKT_LSB  = IN_SEC_LSB + SEC_W;
    localparam int IN_QT_LSB   = IN_PKT_LSB + PKT_W;
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 16;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [0:0] {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND   = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_BEFORE  = 3'd2,
        ST_AFTER   = 3'd3,
        ST_WRITTEN = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_TAIL,
        S_BIS,
        S_UP,
        S_DOWN,
        S_RESP
    } t_state;

    // one classified item as it sits in the queue
    typedef struct packed {
        t_req              kind;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;     // record key for writes, query time for queries
        logic              usable;
    } t_job;

    // back-end status seen by the front end
    typedef struct packed {
        logic queue_full;
        logic clearing;
    } t_front_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/ttbs_front.sv
// Front end: accepts input words, decodes the fields and builds a queue job.
// Computes the record key and usable mark for writes. Depends on ttbs_pkg.
`default_nettype none

module ttbs_front
    import ttbs_pkg::*;
(
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_TDATA_W-1:0] i_s_tdata,
    input  wire logic                  i_s_tuser,
    input  wire t_front_ctl            i_ctl,
    output logic                       o_push,
    output t_job                       o_job
);

    logic [WEEK_W-1:0] week;
    logic [SEC_W-1:0]  sec;
    logic [PKT_W-1:0]  pkt;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  rec_key;
    logic              usable;

    assign week = i_s_tdata[IN_WEEK_LSB +: WEEK_W];
    assign sec  = i_s_tdata[IN_SEC_LSB +: SEC_W];
    assign pkt  = i_s_tdata[IN_PKT_LSB +: PKT_W];

    // week * 604800, then shifted into the fixed point and seconds added
    assign prod    = PROD_W'(week) * PROD_W'(WEEK_SECONDS);
    assign rec_key = {prod, {FRAC_W{1'b0}}} + KEY_W'(sec);
    assign usable  = i_s_tdata[IN_OK_LSB] && (week != '0) && !pkt[PKT_W-1];

    assign o_s_tready = !i_ctl.queue_full && !i_ctl.clearing;
    assign o_push     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_job.kind   = t_req'(i_s_tuser);
        o_job.idx    = i_s_tdata[IN_IDX_LSB +: IDX_W];
        o_job.usable = usable;
        if (o_job.kind == REQ_QUERY) begin
            o_job.key = i_s_tdata[IN_QT_LSB +: KEY_W];
        end else begin
            o_job.key = rec_key;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ttbs_queue.sv
// Short job queue between front and back ends.
// Two-entry FIFO of t_job words; depends on ttbs_pkg.
`default_nettype none

module ttbs_queue
    import ttbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ttbs_back.sv
// Back end: table memory, clearing pass, search sequencer and result register.
// One memory read per probe; depends on ttbs_pkg.
`default_nettype none

module ttbs_back
    import ttbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [COUNT_W-1:0] i_entry_count,
    input  wire logic               i_job_valid,
    input  wire t_job               i_job,
    output logic                    o_pop,
    output logic                    o_clearing,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output t_status                 o_m_status,
    output logic [IDX_W-1:0]        o_m_index
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = IW + 1;
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int XW = ((IW > IDX_W) ? IW : IDX_W) + 1;
    localparam int MW = KEY_W + 1;   // usable mark above the key

    // table: {usable, key}
    logic [MW-1:0] mem [TABLE_DEPTH];
    logic [MW-1:0] r_rd_word;

    t_state          r_state, n_state;
    t_status         r_status, n_status;
    logic [IW-1:0]   r_index, n_index;
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_head_key, n_head_key;
    logic [IW-1:0]   r_head, n_head;
    logic [IW-1:0]   r_tail, n_tail;
    logic [IW-1:0]   r_pos, n_pos;
    logic [IW-1:0]   r_center, n_center;
    logic [CW-1:0]   r_count, n_count;
    logic            r_clr_busy, n_clr_busy;
    logic [IW-1:0]   r_clr_addr, n_clr_addr;
    logic            r_m_valid, n_m_valid;
    t_status         r_m_status, n_m_status;
    logic [IDX_W-1:0] r_m_index, n_m_index;

    logic            we;
    logic [IW-1:0]   wa;
    logic [MW-1:0]   wd;
    logic [IW-1:0]   rd_addr;

    logic [LW-1:0]   cfg_ext;
    logic [LW-1:0]   eff_count;
    logic [CW-1:0]   cnt_m1;
    logic [IW-1:0]   last_pos;
    logic [CW-1:0]   pos_p1;
    logic [IW-1:0]   pos_m1;
    logic [CW-1:0]   mid_sum;
    logic [IW-1:0]   center;
    logic [XW-1:0]   wr_ext;
    logic [XW-1:0]   res_ext;
    logic            rd_usable;
    logic [KEY_W-1:0] rd_key;
    logic            out_free;

    assign cfg_ext   = LW'(i_entry_count);
    assign eff_count = (cfg_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : cfg_ext;
    assign cnt_m1    = r_count - CW'(1);
    assign last_pos  = cnt_m1[IW-1:0];
    assign pos_p1    = {1'b0, r_pos} + CW'(1);
    assign pos_m1    = r_pos - IW'(1);
    assign mid_sum   = {1'b0, r_head} + {1'b0, r_tail};
    assign center    = mid_sum[CW-1:1];
    assign wr_ext    = XW'(i_job.idx);
    assign res_ext   = XW'(r_index);
    assign rd_usable = r_rd_word[MW-1];
    assign rd_key    = r_rd_word[KEY_W-1:0];
    assign out_free  = !r_m_valid || i_m_tready;

    assign o_clearing = r_clr_busy;
    assign o_m_tvalid = r_m_valid;
    assign o_m_status = r_m_status;
    assign o_m_index  = r_m_index;

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_index    = r_index;
        n_key      = r_key;
        n_head_key = r_head_key;
        n_head     = r_head;
        n_tail     = r_tail;
        n_pos      = r_pos;
        n_center   = r_center;
        n_count    = r_count;
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_m_status = r_m_status;
        n_m_index  = r_m_index;
        o_pop      = 1'b0;
        we         = 1'b0;
        wa         = r_clr_addr;
        wd         = '0;
        rd_addr    = r_pos;

        if (r_clr_busy) begin
            we         = 1'b1;
            n_clr_addr = r_clr_addr + IW'(1);
            if (r_clr_addr == IW'(TABLE_DEPTH - 1)) begin
                n_clr_busy = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (!r_clr_busy && i_job_valid) begin
                    o_pop = 1'b1;
                    if (i_job.kind == REQ_WRITE) begin
                        if (wr_ext < XW'(TABLE_DEPTH)) begin
                            we = 1'b1;
                            wa = wr_ext[IW-1:0];
                            wd = {i_job.usable, i_job.key};
                        end
                        n_status = ST_WRITTEN;
                        n_index  = '0;
                        n_state  = S_RESP;
                    end else begin
                        n_key   = i_job.key;
                        n_count = eff_count[CW-1:0];
                        n_index = '0;
                        if (eff_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            rd_addr = '0;
                            n_pos   = '0;
                            n_state = S_HEAD;
                        end
                    end
                end
            end
            // forward scan for the first usable entry
            S_HEAD: begin
                if (rd_usable) begin
                    n_head     = r_pos;
                    n_head_key = rd_key;
                    if (r_key < rd_key) begin
                        n_status = ST_BEFORE;
                        n_state  = S_RESP;
                    end else if (r_pos == last_pos) begin
                        if (r_key > rd_key) begin
                            n_status = ST_AFTER;
                        end else begin
                            n_status = ST_FOUND;
                            n_index  = r_pos;
                        end
                        n_state = S_RESP;
                    end else begin
                        rd_addr = last_pos;
                        n_pos   = last_pos;
                        n_state = S_TAIL;
                    end
                end else if (pos_p1 < r_count) begin
                    rd_addr = pos_p1[IW-1:0];
                    n_pos   = pos_p1[IW-1:0];
                end else begin
                    n_status = ST_EMPTY;
                    n_state  = S_RESP;
                end
            end
            // backward scan for the last usable entry, stopping at the head
            S_TAIL: begin
                if (rd_usable) begin
                    if (r_key > rd_key) begin
                        n_status = ST_AFTER;
                        n_state  = S_RESP;
                    end else begin
                        n_tail  = r_pos;
                        n_state = S_BIS;
                    end
                end else if (pos_m1 == r_head) begin
                    if (r_key > r_head_key) begin
                        n_status = ST_AFTER;
                    end else begin
                        n_status = ST_FOUND;
                        n_index  = r_head;
                    end
                    n_state = S_RESP;
                end else begin
                    rd_addr = pos_m1;
                    n_pos   = pos_m1;
                end
            end
            S_BIS: begin
                if (r_tail - r_head > IW'(1)) begin
                    rd_addr  = center;
                    n_pos    = center;
                    n_center = center;
                    n_state  = S_UP;
                end else begin
                    n_status = ST_FOUND;
                    n_index  = r_tail;
                    n_state  = S_RESP;
                end
            end
            S_UP, S_DOWN: begin
                if (rd_usable) begin
                    if (r_key == rd_key) begin
                        n_status = ST_FOUND;
                        n_index  = r_pos;
                        n_state  = S_RESP;
                    end else if (r_key > rd_key) begin
                        n_head  = r_pos;
                        n_state = S_BIS;
                    end else begin
                        n_tail  = r_pos;
                        n_state = S_BIS;
                    end
                end else if (r_state == S_UP && (r_tail - r_pos > IW'(1))) begin
                    rd_addr = pos_p1[IW-1:0];
                    n_pos   = pos_p1[IW-1:0];
                end else if (r_state == S_UP && (r_center - r_head > IW'(1))) begin
                    // upward probe ran out; go down from just below the midpoint
                    rd_addr = r_center - IW'(1);
                    n_pos   = r_center - IW'(1);
                    n_state = S_DOWN;
                end else if (r_state == S_DOWN && (r_pos - r_head > IW'(1))) begin
                    rd_addr = pos_m1;
                    n_pos   = pos_m1;
                end else begin
                    n_status = ST_FOUND;
                    n_index  = r_tail;
                    n_state  = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_index  = res_ext[IDX_W-1:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_index    <= n_index;
        r_key      <= n_key;
        r_head_key <= n_head_key;
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_pos      <= n_pos;
        r_center   <= n_center;
        r_count    <= n_count;
        r_m_status <= n_m_status;
        r_m_index  <= n_m_index;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_word <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_clear_holds_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (r_state == S_IDLE && !o_pop))
        else $error("job taken during clearing pass");

    a_probe_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP || r_state == S_DOWN) |-> (r_head < r_pos && r_pos < r_tail))
        else $error("probe outside bisection bounds");

    a_tail_above_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL) |-> (r_pos > r_head))
        else $error("tail scan crossed head");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/timestamp_table_binary_search.sv
// Top level of the timestamp table search block: config register and wiring.
// Instantiates ttbs_front, ttbs_queue and ttbs_back; depends on ttbs_pkg.
//
// Usage:
//   s-side words: tuser selects write (0) or query (1). A write stores one
//   record (key = week*604800 s + seconds, usable mark); a query searches
//   entries 0..entry_count-1, capped at TABLE_DEPTH, for query_time. Each
//   word gives one m-side result word: tuser is the status, tdata the found
//   index. The user must have entry_count loaded through the cfg channel
//   (always ready) only while no word is in flight; the block has no check
//   for this. A query scans forward for the first usable entry and backward
//   for the last, then bisects, probing up and then down from each midpoint
//   for a usable entry; each scan step and probe is one read of the single
//   table read port, and early statuses end the search sooner. The next
//   queued word is taken once a result issues. A two-entry queue lets the
//   input side keep taking words while a query runs; a stalled m-side holds
//   its result and the next one waits in the back end, after which the queue
//   fills and s_tready drops. Reset: entry_count clears to 0 and a clearing
//   pass writes every table entry as unusable, during which s_tready is low.
`default_nettype none

module timestamp_table_binary_search
    import ttbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration: entry_count
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [COUNT_W-1:0]     i_cfg_data,
    // tdata: entry_index, entry_time_ok, entry_week, entry_second,
    //        entry_packet_start, query_time, zero pad
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_s_tuser,     // req_type
    // tdata: found_index, zero pad
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic [STATUS_W-1:0]         o_m_tuser      // status
);

    logic [COUNT_W-1:0] r_entry_count;
    t_front_ctl         ctl;
    logic               push;
    t_job               push_job;
    logic               q_full;
    logic               q_valid;
    t_job               q_job;
    logic               pop;
    logic               clearing;
    t_status            m_status;
    logic [IDX_W-1:0]   m_index;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_data;
        end
    end

    assign ctl.queue_full = q_full;
    assign ctl.clearing   = clearing;

    ttbs_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_ctl      (ctl),
        .o_push     (push),
        .o_job      (push_job)
    );

    ttbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ttbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_count (r_entry_count),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_status    (m_status),
        .o_m_index     (m_index)
    );

    assign o_m_tdata = {{(OUT_TDATA_W - IDX_W){1'b0}}, m_index};
    assign o_m_tuser = m_status;

endmodule

`default_nettype wire

>>> tb/sv/ttbs_search_scoreboard_pkg.sv
// Scoreboard for the timestamp table search block: keeps its own record table,
// works out the answer to every accepted word and checks the result words.
// Depends on ttbs_pkg for widths, the input word layout and the status codes.
package ttbs_search_scoreboard_pkg;
    import ttbs_pkg::*;

    localparam int          ROWS      = 1024;
    localparam logic [63:0] WEEK_SPAN = 64'd604800;

    class search_scoreboard;
        typedef struct {
            t_status          status;
            logic [IDX_W-1:0] index;
        } answer_t;

        logic [KEY_W-1:0]   key_mem [ROWS];
        bit                 use_mem [ROWS];
        logic [COUNT_W-1:0] span;
        answer_t            answers [$];
        int                 failures;

        function new();
            foreach (use_mem[i]) begin
                use_mem[i] = 1'b0;
                key_mem[i] = '0;
            end
            span     = '0;
            failures = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] value);
            span = value;
        endfunction

        function bit usable_at(int i);
            return (i >= 0 && i < ROWS) ? use_mem[i] : 1'b0;
        endfunction

        function answer_t search(logic [KEY_W-1:0] q);
            answer_t a;
            int      rows;
            int      head;
            int      tail;
            int      center;
            int      probe;
            bit      hit;
            a.status = ST_FOUND;
            a.index  = '0;
            rows = (span > ROWS) ? ROWS : int'(span);
            head = 0;
            while (head < rows && !use_mem[head])
                head++;
            if (head >= rows) begin
                a.status = ST_EMPTY;
                return a;
            end
            if (q < key_mem[head]) begin
                a.status = ST_BEFORE;
                return a;
            end
            tail = rows - 1;
            while (tail > head && !use_mem[tail])
                tail--;
            if (q > key_mem[tail]) begin
                a.status = ST_AFTER;
                return a;
            end
            while (tail - head > 1) begin
                center = (head + tail) / 2;
                probe  = center;
                hit    = usable_at(probe);
                // look upward first, then downward, strictly inside the bounds
                while (!hit && tail - probe > 1) begin
                    probe++;
                    hit = usable_at(probe);
                end
                if (!hit)
                    probe = center;
                while (!hit && probe - head > 1) begin
                    probe--;
                    hit = usable_at(probe);
                end
                if (!hit)
                    break;
                if (q == key_mem[probe]) begin
                    a.index = IDX_W'(probe);
                    return a;
                end
                if (q > key_mem[probe])
                    head = probe;
                else
                    tail = probe;
            end
            a.index = IDX_W'(tail);
            return a;
        endfunction

        function void note_request(t_req kind, logic [IN_TDATA_W-1:0] w);
            answer_t          a;
            logic [IDX_W-1:0] idx;
            logic [WEEK_W-1:0] week;
            logic [63:0]      base;
            if (kind == REQ_WRITE) begin
                idx  = w[IN_IDX_LSB +: IDX_W];
                week = w[IN_WEEK_LSB +: WEEK_W];
                base = (64'(week) * WEEK_SPAN) << FRAC_W;
                key_mem[idx] = KEY_W'(base + 64'(w[IN_SEC_LSB +: SEC_W]));
                use_mem[idx] = w[IN_OK_LSB] && week != '0 && !w[IN_PKT_LSB + PKT_W - 1];
                a.status = ST_WRITTEN;
                a.index  = '0;
            end else begin
                a = search(w[IN_QT_LSB +: KEY_W]);
            end
            answers.push_back(a);
        endfunction

        function void check_answer(logic [OUT_TDATA_W-1:0] data,
                                   logic [STATUS_W-1:0] status);
            answer_t a;
            if (answers.size() == 0) begin
                failures++;
                $error("result word with nothing outstanding: status %0d, found_index %0d",
                       status, data[IDX_W-1:0]);
                return;
            end
            a = answers.pop_front();
            if (status !== a.status) begin
                failures++;
                $error("status: expected %0d, got %0d", a.status, status);
            end
            if (data[IDX_W-1:0] !== a.index) begin
                failures++;
                $error("found_index: expected %0d, got %0d", a.index, data[IDX_W-1:0]);
            end
        endfunction

        function int outstanding();
            return answers.size();
        endfunction

        function void close_out();
            if (answers.size() != 0) begin
                failures++;
                $error("%0d result words never arrived", answers.size());
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb.sv
// Top-level testbench for timestamp_table_binary_search: drives record writes,
// searches and entry_count settings, with random idling and back-pressure.
// Depends on ttbs_pkg and ttbs_search_scoreboard_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttbs_pkg::*;
    import ttbs_search_scoreboard_pkg::*;

    // watchdog limit, above the clearing pass plus a full-length probe scan
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 1000;
    localparam logic [63:0]       SEC_SPAN = 64'd39636172800;
    localparam logic [SEC_W-1:0]  SEC_TOP  = 36'd39636172799;
    localparam logic [KEY_W-1:0]  KEY_TOP  = '1;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [COUNT_W-1:0]     i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   i_s_tuser   = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [STATUS_W-1:0]    o_m_tuser;

    search_scoreboard sb;
    bit               calm       = 1'b0;
    bit               hold_req   = 1'b0;
    int               words_sent = 0;
    int               quiet      = 0;

    timestamp_table_binary_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return KEY_W'({$urandom, $urandom});
    endfunction

    function automatic logic [SEC_W-1:0] rand_sec();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return SEC_W'(r % SEC_SPAN);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_word(logic [IDX_W-1:0] idx, logic ok,
                                                       logic [WEEK_W-1:0] week,
                                                       logic [SEC_W-1:0] sec,
                                                       logic [PKT_W-1:0] pkt,
                                                       logic [KEY_W-1:0] qt);
        logic [IN_TDATA_W-1:0] w;
        w = '0;
        w[IN_IDX_LSB +: IDX_W]   = idx;
        w[IN_OK_LSB]             = ok;
        w[IN_WEEK_LSB +: WEEK_W] = week;
        w[IN_SEC_LSB +: SEC_W]   = sec;
        w[IN_PKT_LSB +: PKT_W]   = pkt;
        w[IN_QT_LSB +: KEY_W]    = qt;
        return w;
    endfunction

    // valid stays high across back-to-back words; it drops only in a gap
    task automatic send_word(t_req kind, logic [IN_TDATA_W-1:0] w);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 18) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = kind;
        i_s_tdata  = w;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        sb.note_request(kind, w);
        words_sent++;
    endtask

    task automatic write_record(logic [IDX_W-1:0] idx, logic ok, logic [WEEK_W-1:0] week,
                                logic [SEC_W-1:0] sec, logic [PKT_W-1:0] pkt);
        send_word(REQ_WRITE, pack_word(idx, ok, week, sec, pkt, rand_key()));
    endtask

    task automatic ask(logic [KEY_W-1:0] q);
        send_word(REQ_QUERY, pack_word(IDX_W'($urandom), 1'($urandom), WEEK_W'($urandom),
                                       rand_sec(), $urandom, q));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_count(logic [COUNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        sb.set_count(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // rows == 0: no new records, search the whole table as it stands
    task automatic table_phase(int rows, int asks, bit stall_out, bit pause_mid);
        int                 lo;
        int                 last;
        int                 wbase;
        int                 gap_pct;
        int                 r;
        int                 pick;
        int                 live [$];
        logic [COUNT_W-1:0] cnt;
        logic [KEY_W-1:0]   q;
        logic [KEY_W-1:0]   a_key;
        logic [KEY_W-1:0]   b_key;
        logic [KEY_W-1:0]   lo_k;
        logic [63:0]        r64;
        logic [PKT_W-1:0]   pkt;
        drain();
        if (rows == 0) begin
            lo   = 0;
            last = ROWS;
            cnt  = $urandom_range(1) ? COUNT_W'(ROWS) : '1;
        end else begin
            lo   = ($urandom_range(3) == 0 && rows < ROWS) ? $urandom_range(ROWS - rows) : 0;
            last = lo + rows;
            cnt  = (last == ROWS && $urandom_range(1)) ? '1 : COUNT_W'(last);
        end
        set_count(cnt);

        // strictly rising keys on usable rows, with holes of each unusable kind
        wbase   = $urandom_range(1, 65535 - rows);
        gap_pct = $urandom_range(0, 40);
        for (int i = 0; i < rows; i++) begin
            pkt = $urandom & 32'h7FFF_FFFF;
            r   = $urandom_range(99);
            if (r >= gap_pct)
                write_record(IDX_W'(lo + i), 1'b1, WEEK_W'(wbase + i), rand_sec(), pkt);
            else if (r % 3 == 0)
                write_record(IDX_W'(lo + i), 1'b0, WEEK_W'(wbase + i), rand_sec(), pkt);
            else if (r % 3 == 1)
                write_record(IDX_W'(lo + i), 1'b1, '0, rand_sec(), pkt);
            else
                write_record(IDX_W'(lo + i), 1'b1, WEEK_W'(wbase + i), rand_sec(),
                             pkt | 32'h8000_0000);
        end

        for (int i = 0; i < last; i++)
            if (sb.use_mem[i])
                live.push_back(i);

        if (stall_out)
            hold_req = 1'b1;
        for (int k = 0; k < asks; k++) begin
            if (pause_mid && k == asks / 2)
                drain();
            r = $urandom_range(99);
            if (r < 8) begin
                write_record(IDX_W'($urandom_range(last - 1)), 1'($urandom),
                             WEEK_W'($urandom), rand_sec(), $urandom);
            end else if (live.size() == 0) begin
                ask(rand_key());
            end else begin
                pick  = live[$urandom_range(live.size() - 1)];
                a_key = sb.key_mem[pick];
                if (r < 55) begin
                    q = a_key;
                end else if (r < 70) begin
                    q = $urandom_range(1) ? a_key + 1'b1 : a_key - 1'b1;
                end else if (r < 85) begin
                    b_key = sb.key_mem[live[$urandom_range(live.size() - 1)]];
                    lo_k  = (a_key < b_key) ? a_key : b_key;
                    r64   = {$urandom, $urandom};
                    q = lo_k + KEY_W'(r64 % (64'((a_key < b_key) ? b_key - a_key
                                                                  : a_key - b_key) + 1));
                end else if (r < 92) begin
                    q = sb.key_mem[live[0]] - KEY_W'($urandom_range(1, 1000));
                end else begin
                    q = rand_key();
                end
                ask(q);
            end
        end
    endtask

    // result checking and the no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_answer(o_m_tdata, o_m_tuser);
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet++;
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_m_tready = calm || ($urandom_range(99) >= 18);
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] one_key;
        logic [KEY_W-1:0] top_key;
        logic [KEY_W-1:0] mid_key;
        int               n;
        int               rows;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // count still at its reset value: nothing to search
        ask(rand_key());
        drain();
        set_count(11'd4);
        write_record(10'd0, 1'b0, 16'd3, 36'd5, 32'd0);
        write_record(10'd1, 1'b1, 16'd0, SEC_TOP, 32'd0);
        write_record(10'd2, 1'b1, 16'd5, 36'd77, 32'h8000_0000);
        write_record(10'd3, 1'b1, 16'd1, 36'd0, 32'h7FFF_FFFF);
        // one usable record only
        one_key = sb.key_mem[3];
        ask(one_key);
        ask(one_key - 1'b1);
        ask(one_key + 1'b1);
        ask('0);
        ask(KEY_TOP);
        write_record(10'd1023, 1'b1, 16'hFFFF, SEC_TOP, 32'd0);
        top_key = sb.key_mem[1023];
        drain();
        // saturates to the full table; everything between 3 and 1023 is unusable
        set_count('1);
        ask(top_key);
        ask(one_key);
        ask(one_key + 1'b1);
        ask(KEY_TOP);
        write_record(10'd500, 1'b1, 16'd300, 36'd7, 32'd0);
        mid_key = sb.key_mem[500];
        ask(mid_key);
        ask(mid_key + 1'b1);
        ask(mid_key - 1'b1);
        drain();
        set_count('0);
        ask(mid_key);

        n = 0;
        while (words_sent < ITEM_TARGET) begin
            calm = (n == 2) || ($urandom_range(4) == 0);
            if (n == 4 || n == 9)
                rows = 0;
            else if (n == 1)
                rows = 1;
            else
                rows = $urandom_range(2, 48);
            table_phase(rows, $urandom_range(25, 50), n == 3, n == 5 || $urandom_range(5) == 0);
            n++;
        end
        calm = 1'b0;

        drain();
        repeat (40) @(posedge i_clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
